// ----- rtl/modified_utf8_string_decoder_macros.svh -----
// assertion macros shared by the decoder modules
`ifndef MODIFIED_UTF8_STRING_DECODER_MACROS_SVH
`define MODIFIED_UTF8_STRING_DECODER_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define MU8D_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mu8d assertion failed");

// next-cycle implication, quiet while reset is high
`define MU8D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mu8d assertion failed");

`endif

// ----- rtl/mu8d_pkg.sv -----
// types and constants shared by the modified utf-8 decoder modules
`timescale 1ns / 1ps

package mu8d_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_PARTIAL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CLASS_ASCII,
      CLASS_LEAD2,
      CLASS_LEAD3,
      CLASS_CONT,
      CLASS_BAD
   } byte_class_type;

   // one classified operation handed from front to back
   typedef struct packed {
      logic           is_empty;  // zero-length string, report end at once
      logic           first;     // first payload byte of a string
      logic           last;      // final payload byte of a string
      logic           rem_lt2;   // fewer than two bytes follow this one
      byte_class_type cls;
      logic [7:0]     data;
   } op_type;

endpackage

// ----- rtl/modified_utf8_string_decoder.sv -----
// top level of the modified utf-8 string decoder
`timescale 1ns / 1ps
// throughput: one byte per cycle unless the queue is full; classify and decode are combinational
// a byte that completes a result is written into the queue, then into the result register, before rsp_tvalid rises
// the front end and the back end are parted by a short queue, so each stalls on its own
// reset: synchronous, active high; clears framing phase, counters, queue, decode state and the result valid flag
// after reset the decoder expects the high byte of a string length

module modified_utf8_string_decoder #(
   parameter int QueueDepth = mu8d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   // decoded code units and end-of-string status out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] char_value
   output logic        rsp_tlast,   // last: end of the current string
   output logic [2:0]  rsp_tuser    // [0] char_valid, [2:1] status
);

   // operation handed from the front end into the queue
   logic             q_push;
   logic             q_full;
   mu8d_pkg::op_type q_op;

   // head of the queue seen by the back end
   logic             head_valid;
   logic             q_pop;
   mu8d_pkg::op_type head_op;

   // front end: tracks length high, length low and payload phases and
   // classifies each payload byte; length bytes update framing state, and a zero length pushes an empty op
   mu8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_op       (q_op)
   );

   // queue keeps the byte stream moving while the result side is stalled
   mu8d_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   // back end: assembles multi-byte sequences, tracks the string status and
   // drives the result register; units go out before the status is known
   mu8d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/mu8d_front.sv -----
// front end: length framing and byte classification
`timescale 1ns / 1ps

module mu8d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              q_full,
   output logic              q_push,
   output mu8d_pkg::op_type  q_op
);

   typedef enum logic [1:0] {
      PH_LEN_HI  = 2'd0,
      PH_LEN_LO  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [15:0] left_ff, left_in;
   logic        first_ff, first_in;
   logic        accept;
   logic [15:0] new_len;
   mu8d_pkg::byte_class_type cls;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign new_len    = {len_hi_ff, req_tdata};

   always_comb begin
      if (req_tdata[7] == 1'b0) begin
         cls = mu8d_pkg::CLASS_ASCII;
      end else if (req_tdata[7:6] == 2'b10) begin
         cls = mu8d_pkg::CLASS_CONT;
      end else if (req_tdata[7:5] == 3'b110) begin
         cls = mu8d_pkg::CLASS_LEAD2;
      end else if (req_tdata[7:4] == 4'b1110) begin
         cls = mu8d_pkg::CLASS_LEAD3;
      end else begin
         cls = mu8d_pkg::CLASS_BAD;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      len_hi_in = len_hi_ff;
      left_in   = left_ff;
      first_in  = first_ff;
      q_push    = 1'b0;
      q_op.is_empty = 1'b0;
      q_op.first    = first_ff;
      q_op.last     = (left_ff == 16'd1);
      q_op.rem_lt2  = (left_ff < 16'd3);
      q_op.cls      = cls;
      q_op.data     = req_tdata;
      if (accept) begin
         case (phase_ff)
            PH_LEN_LO: begin
               left_in  = new_len;
               first_in = 1'b1;
               if (new_len == 16'd0) begin
                  q_push        = 1'b1;
                  q_op.is_empty = 1'b1;
                  phase_in      = PH_LEN_HI;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               q_push   = 1'b1;
               left_in  = left_ff - 16'd1;
               first_in = 1'b0;
               if (left_ff == 16'd1) begin
                  phase_in = PH_LEN_HI;
               end
            end
            default: begin
               len_hi_in = req_tdata;
               phase_in  = PH_LEN_LO;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEN_HI;
         len_hi_ff <= 8'd0;
         left_ff   <= 16'd0;
         first_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         len_hi_ff <= len_hi_in;
         left_ff   <= left_in;
         first_ff  <= first_in;
      end
   end

endmodule

// ----- rtl/mu8d_queue.sv -----
// short operation queue between front and back
`timescale 1ns / 1ps
`include "modified_utf8_string_decoder_macros.svh"

module mu8d_queue #(
   parameter int QueueDepth = mu8d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mu8d_pkg::op_type  push_op,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output mu8d_pkg::op_type  head_op
);

   localparam int PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);

   mu8d_pkg::op_type slots_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_pop;

   assign full       = (count_ff == CountWidth'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_op    = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `MU8D_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CountWidth'(QueueDepth))
   `MU8D_ASSERT_NOW(a_no_push_full, clock, reset, full, !push)
   `MU8D_ASSERT_NOW(a_empty_ptrs, clock, reset, !head_valid, rd_ptr_ff == wr_ptr_ff)

endmodule

// ----- rtl/mu8d_back.sv -----
// back end: sequence decoding, error tracking and result register
`timescale 1ns / 1ps
`include "modified_utf8_string_decoder_macros.svh"

module mu8d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  mu8d_pkg::op_type  head_op,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic              rsp_tlast,
   output logic [2:0]        rsp_tuser
);

   logic [15:0]          code_ff, code_in;
   logic [1:0]           cont_ff, cont_in;
   mu8d_pkg::status_type err_ff, err_in;

   logic                 out_valid_ff, out_valid_in;
   logic [15:0]          out_char_ff, out_char_in;
   logic                 out_cvalid_ff, out_cvalid_in;
   logic                 out_last_ff, out_last_in;
   mu8d_pkg::status_type out_status_ff, out_status_in;

   logic [15:0]          cur_code;
   logic [1:0]           cur_cont;
   mu8d_pkg::status_type cur_err;
   logic [15:0]          shifted;
   logic                 emit;
   logic                 produce;
   logic [15:0]          ch;

   assign pop = head_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      cur_code = head_op.first ? 16'd0 : code_ff;
      cur_cont = head_op.first ? 2'd0 : cont_ff;
      cur_err  = head_op.first ? mu8d_pkg::STATUS_OK : err_ff;
      shifted  = {cur_code[9:0], head_op.data[5:0]};
      code_in  = code_ff;
      cont_in  = cont_ff;
      err_in   = err_ff;
      emit     = 1'b0;
      ch       = 16'd0;
      produce  = 1'b0;
      if (pop) begin
         if (head_op.is_empty) begin
            cont_in = 2'd0;
            err_in  = mu8d_pkg::STATUS_OK;
            produce = 1'b1;
         end else begin
            code_in = cur_code;
            cont_in = cur_cont;
            err_in  = cur_err;
            if (cur_err != mu8d_pkg::STATUS_OK) begin
               // skip the rest of a failed string
            end else if (cur_cont != 2'd0) begin
               if (head_op.cls != mu8d_pkg::CLASS_CONT) begin
                  err_in  = mu8d_pkg::STATUS_MALFORMED;
                  cont_in = 2'd0;
               end else begin
                  code_in = shifted;
                  cont_in = cur_cont - 2'd1;
                  if (cur_cont == 2'd1) begin
                     emit = 1'b1;
                     ch   = shifted;
                  end
               end
            end else begin
               case (head_op.cls)
                  mu8d_pkg::CLASS_ASCII: begin
                     emit = 1'b1;
                     ch   = {8'd0, head_op.data};
                  end
                  mu8d_pkg::CLASS_LEAD2: begin
                     if (head_op.last) begin
                        err_in = mu8d_pkg::STATUS_PARTIAL;
                     end else begin
                        code_in = {11'd0, head_op.data[4:0]};
                        cont_in = 2'd1;
                     end
                  end
                  mu8d_pkg::CLASS_LEAD3: begin
                     if (head_op.rem_lt2) begin
                        err_in = mu8d_pkg::STATUS_PARTIAL;
                     end else begin
                        code_in = {12'd0, head_op.data[3:0]};
                        cont_in = 2'd2;
                     end
                  end
                  default: begin
                     err_in = mu8d_pkg::STATUS_MALFORMED;
                  end
               endcase
            end
            if (head_op.last) begin
               cont_in = 2'd0;
            end
            produce = head_op.last || emit;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_char_in   = out_char_ff;
      out_cvalid_in = out_cvalid_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (pop && produce) begin
         out_valid_in  = 1'b1;
         out_char_in   = ch;
         out_cvalid_in = emit;
         out_last_in   = head_op.is_empty || head_op.last;
         out_status_in = (head_op.is_empty || !head_op.last) ? mu8d_pkg::STATUS_OK : err_in;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff      <= 16'd0;
         cont_ff      <= 2'd0;
         err_ff       <= mu8d_pkg::STATUS_OK;
         out_valid_ff <= 1'b0;
      end else begin
         code_ff      <= code_in;
         cont_ff      <= cont_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff   <= out_char_in;
      out_cvalid_ff <= out_cvalid_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_status_ff, out_cvalid_ff};

   `MU8D_ASSERT_NOW(a_err_no_cont, clock, reset, err_ff != mu8d_pkg::STATUS_OK, cont_ff == 2'd0)
   `MU8D_ASSERT_NOW(a_cont_range, clock, reset, 1'b1, cont_ff != 2'd3)
   `MU8D_ASSERT_NOW(a_char_ok, clock, reset, out_valid_ff && out_cvalid_ff, out_status_ff == mu8d_pkg::STATUS_OK)
   `MU8D_ASSERT_NOW(a_status_at_end, clock, reset, out_valid_ff && !out_last_ff, out_status_ff == mu8d_pkg::STATUS_OK)

endmodule

// ----- tb/modified_utf8_string_decoder_checker.sv -----
// checker for the modified utf-8 string decoder: predicts and compares results
`timescale 1ns / 1ps

module modified_utf8_string_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [15:0] char_value
   input  logic        rsp_tlast,
   input  logic [2:0]  rsp_tuser,   // [0] char_valid, [2:1] status
   output int          outstanding,
   output int          fault_count
);

   typedef enum logic [1:0] {
      FRAME_LEN_HI,
      FRAME_LEN_LO,
      FRAME_PAYLOAD
   } frame_state_type;

   typedef struct {
      logic [15:0]          char_value;
      logic                 char_valid;
      logic                 last;
      mu8d_pkg::status_type status;
   } unit_result_type;

   // decoder state as the predictor sees it
   frame_state_type      frame;
   logic [7:0]           len_hi;
   logic [15:0]          left;
   logic [15:0]          code;
   logic [1:0]           conts;
   mu8d_pkg::status_type err;

   unit_result_type due_units[$];
   int              errors = 0;

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 100)
         $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   function automatic void clear_decoder();
      frame  = FRAME_LEN_HI;
      len_hi = '0;
      left   = '0;
      code   = '0;
      conts  = '0;
      err    = mu8d_pkg::STATUS_OK;
   endfunction

   // one stream byte in, at most one result out
   function automatic bit decode_byte(input logic [7:0] b, output unit_result_type r);
      logic [15:0] rem;
      logic        emit;
      logic [15:0] unit;
      r.char_value = '0;
      r.char_valid = 1'b0;
      r.last       = 1'b0;
      r.status     = mu8d_pkg::STATUS_OK;
      emit = 1'b0;
      unit = '0;
      case (frame)
         FRAME_LEN_LO: begin
            left  = {len_hi, b};
            code  = '0;
            conts = '0;
            err   = mu8d_pkg::STATUS_OK;
            if (left == 16'd0) begin
               frame  = FRAME_LEN_HI;
               r.last = 1'b1;
               return 1'b1;
            end
            frame = FRAME_PAYLOAD;
            return 1'b0;
         end
         FRAME_PAYLOAD: begin
            rem  = left - 16'd1;
            left = rem;
            if (err != mu8d_pkg::STATUS_OK) begin
               // rest of a failed string is swallowed
            end else if (conts != 2'd0) begin
               if (b[7:6] != 2'b10) begin
                  err   = mu8d_pkg::STATUS_MALFORMED;
                  conts = '0;
               end else begin
                  code  = {code[9:0], b[5:0]};
                  conts = conts - 2'd1;
                  if (conts == 2'd0) begin
                     emit = 1'b1;
                     unit = code;
                  end
               end
            end else if (b[7] == 1'b0) begin
               emit = 1'b1;
               unit = {8'h00, b};
            end else if (b[7:5] == 3'b110) begin
               if (rem < 16'd1) err = mu8d_pkg::STATUS_PARTIAL;
               else begin
                  code  = {11'd0, b[4:0]};
                  conts = 2'd1;
               end
            end else if (b[7:4] == 4'b1110) begin
               if (rem < 16'd2) err = mu8d_pkg::STATUS_PARTIAL;
               else begin
                  code  = {12'd0, b[3:0]};
                  conts = 2'd2;
               end
            end else begin
               err = mu8d_pkg::STATUS_MALFORMED;
            end
            if (rem == 16'd0) begin
               frame        = FRAME_LEN_HI;
               conts        = '0;
               r.last       = 1'b1;
               r.status     = err;
               r.char_valid = emit && (err == mu8d_pkg::STATUS_OK);
               r.char_value = r.char_valid ? unit : 16'd0;
               return 1'b1;
            end
            if (emit) begin
               r.char_value = unit;
               r.char_valid = 1'b1;
               return 1'b1;
            end
            return 1'b0;
         end
         default: begin
            len_hi = b;
            frame  = FRAME_LEN_LO;
            return 1'b0;
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      unit_result_type want;
      unit_result_type made;
      if (reset) begin
         clear_decoder();
         due_units.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_units.size() == 0) begin
               report_mismatch($sformatf("result %h with nothing expected", rsp_tdata));
            end else begin
               want = due_units.pop_front();
               if (rsp_tdata !== want.char_value)
                  report_mismatch($sformatf("char_value %h, wanted %h",
                                            rsp_tdata, want.char_value));
               if (rsp_tuser[0] !== want.char_valid)
                  report_mismatch($sformatf("char_valid %b, wanted %b",
                                            rsp_tuser[0], want.char_valid));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last %b, wanted %b", rsp_tlast, want.last));
               if (rsp_tuser[2:1] !== want.status)
                  report_mismatch($sformatf("status %0d, wanted %0d",
                                            rsp_tuser[2:1], want.status));
            end
         end
         if (req_tvalid && req_tready) begin
            if (decode_byte(req_tdata, made))
               due_units.push_back(made);
         end
      end
      outstanding <= due_units.size();
      fault_count <= errors;
   end

endmodule

// ----- tb/modified_utf8_string_decoder_tb.sv -----
// testbench top for the modified utf-8 string decoder: stimulus and verdict
`timescale 1ns / 1ps

module modified_utf8_string_decoder_tb;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [15:0] char_value
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;    // [0] char_valid, [2:1] status

   int outstanding;
   int fault_count;

   // payload of the string being built, length is taken from its size
   logic [7:0]  payload[$];
   int unsigned bytes_sent = 0;
   bit          brisk = 1'b0;   // sender runs without gaps for this string

   modified_utf8_string_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   modified_utf8_string_decoder_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .outstanding (outstanding),
      .fault_count (fault_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // one byte transaction on req, with a random gap in front of it
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = brisk ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // big-endian length first, then the payload
   task automatic send_string();
      logic [15:0] len;
      len = 16'(payload.size());
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      foreach (payload[i]) send_byte(payload[i]);
   endtask

   // well-formed text of exactly the given byte count, sequence lengths mixed
   task automatic make_text(input int unsigned target);
      int unsigned room;
      int unsigned span;
      logic [15:0] u;
      payload.delete();
      while (payload.size() < target) begin
         room = target - payload.size();
         span = $urandom_range(1, (room < 3) ? room : 3);
         u    = 16'($urandom);
         case (span)
            1: begin
               payload.push_back({1'b0, u[6:0]});
            end
            2: begin
               payload.push_back({3'b110, u[10:6]});
               payload.push_back({2'b10, u[5:0]});
            end
            default: begin
               payload.push_back({4'b1110, u[15:12]});
               payload.push_back({2'b10, u[11:6]});
               payload.push_back({2'b10, u[5:0]});
            end
         endcase
      end
   endtask

   // hold the sender back until every expected result has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // result side: random stall before each transaction, with calm stretches
   initial begin : sink
      int unsigned stall;
      int unsigned taken;
      bit          calm;
      rsp_tready = 1'b0;
      taken = 0;
      calm  = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         stall = calm ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   initial begin : stimulus
      int unsigned pick;
      int unsigned idx;
      int unsigned n;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty string
      payload.delete();
      send_string();
      // ascii extremes, two-byte and three-byte units, unit on the final byte
      payload = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF};
      send_string();
      // three-byte lead with only one byte left
      payload = '{8'hEF, 8'h80};
      send_string();
      // two-byte lead as the final byte
      payload = '{8'hC3};
      send_string();
      // bad lead byte, then the rest is skipped
      payload = '{8'hFF, 8'h41};
      send_string();
      // bad continuation byte
      payload = '{8'hC3, 8'h41};
      send_string();
      drain();

      // one long string so the length high byte is non-zero
      make_text(256 + $urandom_range(0, 40));
      send_string();

      while (bytes_sent < 1650) begin
         brisk = ($urandom_range(0, 4) == 0);
         pick  = $urandom_range(0, 99);
         if (pick < 65) begin
            make_text($urandom_range(0, 24));
         end else if (pick < 80) begin
            // one byte overwritten with anything
            make_text($urandom_range(1, 24));
            idx = $urandom_range(0, payload.size() - 1);
            payload[idx] = 8'($urandom);
         end else if (pick < 90) begin
            // cut short, so a trailing lead may run past the length
            make_text($urandom_range(2, 24));
            void'(payload.pop_back());
         end else begin
            n = $urandom_range(0, 16);
            payload.delete();
            repeat (n) payload.push_back(8'($urandom));
         end
         send_string();
         if ($urandom_range(0, 29) == 0) drain();
      end

      drain();
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("PASS modified_utf8_string_decoder");
      end else begin
         $display("FAIL modified_utf8_string_decoder");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin : watchdog
      #5_000_000;
      $display("FAIL modified_utf8_string_decoder");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mu8d_pkg.sv
rtl/mu8d_front.sv
rtl/mu8d_queue.sv
rtl/mu8d_back.sv
rtl/modified_utf8_string_decoder.sv
tb/modified_utf8_string_decoder_checker.sv
tb/modified_utf8_string_decoder_tb.sv
